// File: hdl/efa_pkg.sv
`default_nettype none

package efa_pkg;

    typedef enum logic [4:0] {
        OP_ADD   = 5'd0,
        OP_ADC   = 5'd1,
        OP_SUB   = 5'd2,
        OP_SBC   = 5'd3,
        OP_INC   = 5'd4,
        OP_DEC   = 5'd5,
        OP_AND   = 5'd6,
        OP_OR    = 5'd7,
        OP_XOR   = 5'd8,
        OP_BIT   = 5'd9,
        OP_RLC   = 5'd10,
        OP_RL    = 5'd11,
        OP_RRC   = 5'd12,
        OP_RR    = 5'd13,
        OP_CP    = 5'd14,
        OP_CPL   = 5'd15,
        OP_SWAP  = 5'd16,
        OP_ADD16 = 5'd17,
        OP_INC16 = 5'd18,
        OP_DEC16 = 5'd19
    } t_op;

    typedef struct packed {
        logic zero;
        logic subtract;
        logic half_carry;
        logic carry;
    } t_flags;

    typedef struct packed {
        logic [4:0]  req_type;
        logic [15:0] operand_a;
        logic [15:0] operand_b;
        logic [2:0]  bit_index;
    } t_req;

    typedef struct packed {
        logic [15:0] result_value;
        logic        zero_out;
        logic        subtract_out;
        logic        half_carry_out;
        logic        carry_out;
    } t_rsp;

    localparam t_flags FLAGS_CLEAR = '{zero: 1'b0, subtract: 1'b0,
                                       half_carry: 1'b0, carry: 1'b0};

endpackage

`default_nettype wire

// File: hdl/efa_stream_if.sv
`default_nettype none

interface efa_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: hdl/eight_bit_alu_with_flags_core.sv
// Channel   Modport  Payload          Request
// i_req     sink     efa_pkg::t_req   operation, operands, bit index
// o_rsp     source   efa_pkg::t_rsp   result value and flags
//
// One request per cycle unless the result stalls; results are offered from the result register.
// The flag register is written as each request moves from the input register to the
// result register, so the next request in the input register sees it at once.
// Synchronous active-low reset clears both valid bits and all flags.
// A stalled result holds the result register; the input register still fills behind it.
`default_nettype none

module eight_bit_alu_with_flags_core (
    input  wire           i_clk,
    input  wire           i_rst_n,
    efa_stream_if.sink    i_req,
    efa_stream_if.source  o_rsp
);

    logic           r_in_valid;
    efa_pkg::t_req  r_in;
    logic           r_out_valid;
    logic [15:0]    r_result;
    efa_pkg::t_flags r_flags;

    logic            advance;
    logic [15:0]     n_result;
    efa_pkg::t_flags n_flags;

    logic [7:0]  a;
    logic [7:0]  b;
    logic        cin_add;
    logic        cin_sub;
    logic [8:0]  sum9;
    logic [4:0]  hsum5;
    logic [8:0]  dif9;
    logic [4:0]  hdif5;
    logic [16:0] sum17;
    logic [12:0] hsum13;

    assign advance     = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || advance;

    assign a       = r_in.operand_a[7:0];
    assign b       = r_in.operand_b[7:0];
    assign cin_add = (r_in.req_type == efa_pkg::OP_ADC) && r_flags.carry;
    assign cin_sub = (r_in.req_type == efa_pkg::OP_SBC) && r_flags.carry;
    assign sum9  = {1'b0, a} + {1'b0, b} + {8'd0, cin_add};
    assign hsum5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin_add};
    assign dif9  = {1'b0, a} - {1'b0, b} - {8'd0, cin_sub};
    assign hdif5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cin_sub};
    assign sum17  = {1'b0, r_in.operand_a} + {1'b0, r_in.operand_b};
    assign hsum13 = {1'b0, r_in.operand_a[11:0]} + {1'b0, r_in.operand_b[11:0]};

    always_comb begin
        n_result = r_in.operand_a;
        n_flags  = r_flags;
        case (r_in.req_type)
            efa_pkg::OP_ADD, efa_pkg::OP_ADC: begin
                n_result = {8'd0, sum9[7:0]};
                n_flags  = '{zero: (sum9[7:0] == 8'd0), subtract: 1'b0,
                             half_carry: hsum5[4], carry: sum9[8]};
            end
            efa_pkg::OP_SUB, efa_pkg::OP_SBC, efa_pkg::OP_CP: begin
                if (r_in.req_type != efa_pkg::OP_CP) begin
                    n_result = {8'd0, dif9[7:0]};
                end
                n_flags = '{zero: (dif9[7:0] == 8'd0), subtract: 1'b1,
                            half_carry: hdif5[4], carry: dif9[8]};
            end
            efa_pkg::OP_INC: begin
                n_result = {8'd0, a + 8'd1};
                n_flags  = '{zero: (a == 8'hFF), subtract: 1'b0,
                             half_carry: (a[3:0] == 4'hF), carry: r_flags.carry};
            end
            efa_pkg::OP_DEC: begin
                n_result = {8'd0, a - 8'd1};
                n_flags  = '{zero: (a == 8'h01), subtract: 1'b1,
                             half_carry: (a[3:0] == 4'h0), carry: r_flags.carry};
            end
            efa_pkg::OP_AND: begin
                n_result = {8'd0, a & b};
                n_flags  = '{zero: ((a & b) == 8'd0), subtract: 1'b0,
                             half_carry: 1'b1, carry: 1'b0};
            end
            efa_pkg::OP_OR: begin
                n_result = {8'd0, a | b};
                n_flags  = '{zero: ((a | b) == 8'd0), subtract: 1'b0,
                             half_carry: 1'b0, carry: 1'b0};
            end
            efa_pkg::OP_XOR: begin
                n_result = {8'd0, a ^ b};
                n_flags  = '{zero: ((a ^ b) == 8'd0), subtract: 1'b0,
                             half_carry: 1'b0, carry: 1'b0};
            end
            efa_pkg::OP_BIT: begin
                n_flags = '{zero: !a[r_in.bit_index], subtract: 1'b0,
                            half_carry: 1'b1, carry: r_flags.carry};
            end
            efa_pkg::OP_RLC: begin
                n_result = {8'd0, a[6:0], a[7]};
                n_flags  = '{zero: (a == 8'd0), subtract: 1'b0,
                             half_carry: 1'b0, carry: a[7]};
            end
            efa_pkg::OP_RL: begin
                n_result = {8'd0, a[6:0], r_flags.carry};
                n_flags  = '{zero: ({a[6:0], r_flags.carry} == 8'd0), subtract: 1'b0,
                             half_carry: 1'b0, carry: a[7]};
            end
            efa_pkg::OP_RRC: begin
                n_result = {8'd0, a[0], a[7:1]};
                n_flags  = '{zero: (a == 8'd0), subtract: 1'b0,
                             half_carry: 1'b0, carry: a[0]};
            end
            efa_pkg::OP_RR: begin
                n_result = {8'd0, r_flags.carry, a[7:1]};
                n_flags  = '{zero: ({r_flags.carry, a[7:1]} == 8'd0), subtract: 1'b0,
                             half_carry: 1'b0, carry: a[0]};
            end
            efa_pkg::OP_CPL: begin
                n_result = {8'd0, ~a};
                n_flags  = '{zero: r_flags.zero, subtract: 1'b1,
                             half_carry: 1'b1, carry: r_flags.carry};
            end
            efa_pkg::OP_SWAP: begin
                n_result = {8'd0, a[3:0], a[7:4]};
                n_flags  = '{zero: (a == 8'd0), subtract: 1'b0,
                             half_carry: 1'b0, carry: 1'b0};
            end
            efa_pkg::OP_ADD16: begin
                n_result = sum17[15:0];
                n_flags  = '{zero: r_flags.zero, subtract: 1'b0,
                             half_carry: hsum13[12], carry: sum17[16]};
            end
            efa_pkg::OP_INC16: begin
                n_result = r_in.operand_a + 16'd1;
            end
            efa_pkg::OP_DEC16: begin
                n_result = r_in.operand_a - 16'd1;
            end
            default: begin
                n_result = r_in.operand_a;
                n_flags  = r_flags;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_flags     <= efa_pkg::FLAGS_CLEAR;
        end else begin
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_flags     <= n_flags;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in <= i_req.payload;
        end
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = '{result_value: r_result, zero_out: r_flags.zero,
                             subtract_out: r_flags.subtract,
                             half_carry_out: r_flags.half_carry,
                             carry_out: r_flags.carry};

`ifndef ASSERT_OFF
    a_result_after_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("result register empty after a request advanced");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_rsp.ready) |=> (r_out_valid && $stable(r_result)
            && $stable(r_flags)))
        else $error("stalled result changed");

    a_flags_kept_16: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (r_in.req_type == efa_pkg::OP_INC16
            || r_in.req_type == efa_pkg::OP_DEC16)) |=> $stable(r_flags))
        else $error("16-bit inc or dec changed the flags");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |-> !i_req.ready)
        else $error("input register accepted while full");
`endif

endmodule

`default_nettype wire

// File: dv/eight_bit_alu_with_flags_core_tb.sv
`timescale 1ns / 100ps

module eight_bit_alu_with_flags_core_tb;

    localparam int CLK_PERIOD = 12;
    localparam int RESET_CYCLES = 5;
    localparam int TIMEOUT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 4;
    localparam int HOLD_CYCLES = 60;

    localparam logic [4:0] OP_UNUSED_LO = 5'd20;
    localparam logic [4:0] OP_UNUSED_HI = 5'd31;

    logic i_clk;
    logic i_rst_n;

    efa_stream_if #(.t_payload(efa_pkg::t_req)) req_if ();
    efa_stream_if #(.t_payload(efa_pkg::t_rsp)) rsp_if ();

    eight_bit_alu_with_flags_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    efa_pkg::t_flags flag_reg = efa_pkg::FLAGS_CLEAR;
    efa_pkg::t_rsp   pending_results[$];
    efa_pkg::t_rsp   expected_rsp;
    int     err_count = 0;
    int     send_idle_pct = 0;
    int     rsp_stall_pct = 0;
    int     hold_left = 0;
    event   hold_kick;

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("status: fail");
        $finish;
    end

    function automatic efa_pkg::t_rsp predict_alu_result(input efa_pkg::t_req r);
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  res8;
        logic        cin;
        logic        t;
        logic [8:0]  sum9;
        logic [4:0]  sum5;
        logic [16:0] sum17;
        logic [12:0] sum13;
        efa_pkg::t_flags f;
        efa_pkg::t_rsp   rsp;
        a = r.operand_a[7:0];
        b = r.operand_b[7:0];
        f = flag_reg;
        cin = f.carry;
        t = 1'b0;
        rsp.result_value = r.operand_a;
        case (r.req_type)
            efa_pkg::OP_ADD, efa_pkg::OP_ADC: begin
                t = (r.req_type == efa_pkg::OP_ADC) ? cin : 1'b0;
                sum9 = {1'b0, a} + {1'b0, b} + t;
                sum5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + t;
                rsp.result_value = {8'h00, sum9[7:0]};
                f = '{sum9[7:0] == 8'h00, 1'b0, sum5[4], sum9[8]};
            end
            efa_pkg::OP_SUB, efa_pkg::OP_SBC, efa_pkg::OP_CP: begin
                t = (r.req_type == efa_pkg::OP_SBC) ? cin : 1'b0;
                res8 = a - b - t;
                f = '{res8 == 8'h00, 1'b1,
                      {1'b0, a[3:0]} < ({1'b0, b[3:0]} + t),
                      {1'b0, a} < ({1'b0, b} + t)};
                if (r.req_type != efa_pkg::OP_CP) begin
                    rsp.result_value = {8'h00, res8};
                end
            end
            efa_pkg::OP_INC: begin
                res8 = a + 8'h01;
                rsp.result_value = {8'h00, res8};
                f = '{res8 == 8'h00, 1'b0, a[3:0] == 4'hF, cin};
            end
            efa_pkg::OP_DEC: begin
                res8 = a - 8'h01;
                rsp.result_value = {8'h00, res8};
                f = '{res8 == 8'h00, 1'b1, a[3:0] == 4'h0, cin};
            end
            efa_pkg::OP_AND: begin
                res8 = a & b;
                rsp.result_value = {8'h00, res8};
                f = '{res8 == 8'h00, 1'b0, 1'b1, 1'b0};
            end
            efa_pkg::OP_OR: begin
                res8 = a | b;
                rsp.result_value = {8'h00, res8};
                f = '{res8 == 8'h00, 1'b0, 1'b0, 1'b0};
            end
            efa_pkg::OP_XOR: begin
                res8 = a ^ b;
                rsp.result_value = {8'h00, res8};
                f = '{res8 == 8'h00, 1'b0, 1'b0, 1'b0};
            end
            efa_pkg::OP_BIT: begin
                f = '{!a[r.bit_index], 1'b0, 1'b1, cin};
            end
            efa_pkg::OP_RLC: begin
                res8 = {a[6:0], a[7]};
                rsp.result_value = {8'h00, res8};
                f = '{res8 == 8'h00, 1'b0, 1'b0, a[7]};
            end
            efa_pkg::OP_RL: begin
                res8 = {a[6:0], cin};
                rsp.result_value = {8'h00, res8};
                f = '{res8 == 8'h00, 1'b0, 1'b0, a[7]};
            end
            efa_pkg::OP_RRC: begin
                res8 = {a[0], a[7:1]};
                rsp.result_value = {8'h00, res8};
                f = '{res8 == 8'h00, 1'b0, 1'b0, a[0]};
            end
            efa_pkg::OP_RR: begin
                res8 = {cin, a[7:1]};
                rsp.result_value = {8'h00, res8};
                f = '{res8 == 8'h00, 1'b0, 1'b0, a[0]};
            end
            efa_pkg::OP_CPL: begin
                rsp.result_value = {8'h00, ~a};
                f.subtract = 1'b1;
                f.half_carry = 1'b1;
            end
            efa_pkg::OP_SWAP: begin
                res8 = {a[3:0], a[7:4]};
                rsp.result_value = {8'h00, res8};
                f = '{res8 == 8'h00, 1'b0, 1'b0, 1'b0};
            end
            efa_pkg::OP_ADD16: begin
                sum17 = {1'b0, r.operand_a} + {1'b0, r.operand_b};
                sum13 = {1'b0, r.operand_a[11:0]} + {1'b0, r.operand_b[11:0]};
                rsp.result_value = sum17[15:0];
                f.subtract = 1'b0;
                f.half_carry = sum13[12];
                f.carry = sum17[16];
            end
            efa_pkg::OP_INC16: begin
                rsp.result_value = r.operand_a + 16'h0001;
            end
            efa_pkg::OP_DEC16: begin
                rsp.result_value = r.operand_a - 16'h0001;
            end
            default: begin
            end
        endcase
        flag_reg = f;
        rsp.zero_out = f.zero;
        rsp.subtract_out = f.subtract;
        rsp.half_carry_out = f.half_carry;
        rsp.carry_out = f.carry;
        return rsp;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready) begin
                pending_results.push_back(predict_alu_result(req_if.payload));
            end
            if (rsp_if.valid && rsp_if.ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, rsp_if.payload);
                    err_count++;
                end else begin
                    expected_rsp = pending_results.pop_front();
                    check_field("result_value", expected_rsp.result_value,
                                rsp_if.payload.result_value);
                    check_field("zero_out", 16'(expected_rsp.zero_out),
                                16'(rsp_if.payload.zero_out));
                    check_field("subtract_out", 16'(expected_rsp.subtract_out),
                                16'(rsp_if.payload.subtract_out));
                    check_field("half_carry_out", 16'(expected_rsp.half_carry_out),
                                16'(rsp_if.payload.half_carry_out));
                    check_field("carry_out", 16'(expected_rsp.carry_out),
                                16'(rsp_if.payload.carry_out));
                end
            end
        end
    end

    // hold off the result channel while the counter runs
    always begin
        @(hold_kick);
        hold_left <= HOLD_CYCLES;
        repeat (HOLD_CYCLES) begin
            @(posedge i_clk);
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        rsp_if.ready <= (hold_left == 0) && ($urandom_range(99) >= rsp_stall_pct);
    end

    task automatic set_pace(input int send_pct, input int stall_pct);
        send_idle_pct = send_pct;
        rsp_stall_pct <= stall_pct;
    endtask

    task automatic send_req(input efa_pkg::t_req r);
        if ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        req_if.valid <= 1'b1;
        req_if.payload <= r;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    task automatic wait_drain();
        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    function automatic efa_pkg::t_req make_req(input logic [4:0] op,
                                               input logic [15:0] a,
                                               input logic [15:0] b,
                                               input logic [2:0] idx);
        efa_pkg::t_req r;
        r.req_type = op;
        r.operand_a = a;
        r.operand_b = b;
        r.bit_index = idx;
        return r;
    endfunction

    function automatic logic [15:0] random_operand();
        case ($urandom_range(9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h0FFF;
            3: return 16'h00FF;
            4: return {8'($urandom_range(255)), 4'($urandom_range(15)), 4'hF};
            5: return {8'($urandom_range(255)), 4'($urandom_range(15)), 4'h0};
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic efa_pkg::t_req random_req();
        logic [4:0] op;
        if ($urandom_range(99) < 5) begin
            op = 5'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
        end else begin
            op = 5'($urandom_range(efa_pkg::OP_DEC16, efa_pkg::OP_ADD));
        end
        return make_req(op, random_operand(), random_operand(), 3'($urandom_range(7)));
    endfunction

    task automatic run_random(input int count);
        repeat (count) send_req(random_req());
        wait_drain();
    endtask

    task automatic test_directed_ops();
        set_pace(0, 0);
        send_req(make_req(efa_pkg::OP_ADD,   16'h00FF, 16'h0001, 3'd0));
        send_req(make_req(efa_pkg::OP_ADC,   16'h000F, 16'h00F0, 3'd0));
        send_req(make_req(efa_pkg::OP_SUB,   16'hFF00, 16'hFF01, 3'd0));
        send_req(make_req(efa_pkg::OP_SBC,   16'h0010, 16'h000F, 3'd0));
        send_req(make_req(efa_pkg::OP_INC,   16'hABFF, 16'h0000, 3'd0));
        send_req(make_req(efa_pkg::OP_DEC,   16'h1200, 16'h0000, 3'd0));
        send_req(make_req(efa_pkg::OP_AND,   16'hFFF0, 16'hFF0F, 3'd0));
        send_req(make_req(efa_pkg::OP_OR,    16'h0000, 16'h0000, 3'd0));
        send_req(make_req(efa_pkg::OP_XOR,   16'h55AA, 16'hAA55, 3'd0));
        send_req(make_req(efa_pkg::OP_BIT,   16'hFF7F, 16'hFFFF, 3'd7));
        send_req(make_req(efa_pkg::OP_BIT,   16'h8001, 16'h0000, 3'd0));
        send_req(make_req(efa_pkg::OP_RLC,   16'h0080, 16'h0000, 3'd0));
        send_req(make_req(efa_pkg::OP_RL,    16'hFF80, 16'h0000, 3'd0));
        send_req(make_req(efa_pkg::OP_RRC,   16'h0001, 16'h0000, 3'd0));
        send_req(make_req(efa_pkg::OP_RR,    16'h0001, 16'h0000, 3'd0));
        send_req(make_req(efa_pkg::OP_CP,    16'hBE42, 16'h0042, 3'd0));
        send_req(make_req(efa_pkg::OP_CPL,   16'hFF00, 16'h0000, 3'd0));
        send_req(make_req(efa_pkg::OP_SWAP,  16'h00F0, 16'h0000, 3'd0));
        send_req(make_req(efa_pkg::OP_ADD16, 16'hFFFF, 16'h0001, 3'd0));
        send_req(make_req(efa_pkg::OP_ADD16, 16'h0FFF, 16'h0001, 3'd0));
        send_req(make_req(efa_pkg::OP_INC16, 16'hFFFF, 16'h0000, 3'd0));
        send_req(make_req(efa_pkg::OP_DEC16, 16'h0000, 16'h0000, 3'd0));
        send_req(make_req(OP_UNUSED_LO, 16'hFFFF, 16'hFFFF, 3'd7));
        send_req(make_req(OP_UNUSED_HI, 16'h1234, 16'h0000, 3'd0));
        wait_drain();
    endtask

    task automatic test_back_to_back();
        set_pace(0, 0);
        run_random(150);
    endtask

    task automatic test_sender_gaps();
        set_pace(71, 0);
        run_random(150);
    endtask

    task automatic test_receiver_stalls();
        set_pace(0, 71);
        run_random(150);
    endtask

    task automatic test_mixed_gaps();
        set_pace(15, 15);
        run_random(150);
    endtask

    task automatic test_fill_and_stall();
        set_pace(0, 0);
        -> hold_kick;
        run_random(40);
    endtask

    initial begin
        i_rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.payload = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_ops();
        test_back_to_back();
        test_sender_gaps();
        test_receiver_stalls();
        test_mixed_gaps();
        test_fill_and_stall();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0 && pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
